// ===== src/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types and constants of the mask centroid follow command block.
// ----------------------------------------------------------------------------
package mcf_pkg;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FORWARD_GAIN = 2'd2,
    REG_TURN_GAIN    = 2'd3
  } reg_idx_e;

  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd960;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd540;
  localparam logic [15:0] FORWARD_GAIN_RST = 16'd131;  // 0.002 in Q0.16
  localparam logic [15:0] TURN_GAIN_RST    = 16'd197;  // 0.003 in Q0.16

  typedef logic signed [27:0] speed_t;

  localparam logic signed [47:0] SPEED_HI = 48'sd67108864;
  localparam logic signed [47:0] SPEED_LO = -48'sd67108864;

  typedef struct packed {
    logic          target_found;
    logic [10:0]   centroid_x;
    logic [10:0]   centroid_y;
    logic [22:0]   set_pixel_count;
    speed_t        forward_speed;
    speed_t        turn_speed;
  } result_t;

  function automatic speed_t speed_sat(input logic signed [47:0] v);
    speed_t r;
    if (v > SPEED_HI) begin
      r = speed_t'(SPEED_HI);
    end else if (v < SPEED_LO) begin
      r = speed_t'(SPEED_LO);
    end else begin
      r = speed_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/mask_centroid_follow_command.sv =====
// ----------------------------------------------------------------------------
// mask_centroid_follow_command
// Binary mask centroid with proportional forward and turn commands.
// ----------------------------------------------------------------------------
// Takes one mask pixel per clock in raster order and gives one result per
// frame after its last pixel. The front end sums set pixel positions at one
// pixel a cycle; completed frames wait in a two-entry queue for the back end,
// which works on one frame at a time with a bit-serial divider, one multiply
// and a saturate step. Input stalls (full high) only while that queue is full,
// which needs frames shorter than the back end's work per frame or results
// left unread.
// Registers: 0x0 frame_width, 0x4 frame_height, 0x8 forward_gain,
// 0xC turn_gain (Q0.16).
module mask_centroid_follow_command #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mcf_pkg::CFG_AW-1:0] paddr,
  input  logic [mcf_pkg::CFG_DW-1:0] pwdata,
  output logic [mcf_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic                       pixel_on_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       target_found_o,
  output logic [10:0]                centroid_x_o,
  output logic [10:0]                centroid_y_o,
  output logic [22:0]                set_pixel_count_o,
  output mcf_pkg::speed_t            forward_speed_o,
  output mcf_pkg::speed_t            turn_speed_o
);

  import mcf_pkg::*;

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned QW  = (XW > YW) ? XW : YW;
  localparam int unsigned CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SW  = CW + QW;
  localparam int unsigned HXW = $clog2(MAX_WIDTH / 2 + 1);
  localparam int unsigned HYW = $clog2(MAX_HEIGHT / 2 + 1);
  localparam int unsigned RW  = 2 * SW + CW + HXW + HYW + 32;

  logic [11:0]    frame_width_q, frame_height_q;
  logic [15:0]    forward_gain_q, turn_gain_q;
  reg_idx_e       reg_idx;
  logic           cfg_wr, take;

  logic           rec_valid, rec_full, rec_empty, rec_pop;
  logic [SW-1:0]  f_sum_x, f_sum_y, b_sum_x, b_sum_y;
  logic [CW-1:0]  f_count, b_count;
  logic [HXW-1:0] f_half_w, b_half_w;
  logic [HYW-1:0] f_half_h, b_half_h;
  logic [15:0]    b_fgain, b_tgain;
  logic [RW-1:0]  rec_wdata, rec_rdata;

  logic           res_push, res_full;
  result_t        res_w, res_r;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DW'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(frame_height_q);
      REG_FORWARD_GAIN: prdata = CFG_DW'(forward_gain_q);
      REG_TURN_GAIN:    prdata = CFG_DW'(turn_gain_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      forward_gain_q <= FORWARD_GAIN_RST;
      turn_gain_q    <= TURN_GAIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[11:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[11:0];
        REG_FORWARD_GAIN: forward_gain_q <= pwdata[15:0];
        REG_TURN_GAIN:    turn_gain_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign full = rec_full;
  assign take = push && !rec_full;

  mcf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .take_i         (take),
    .pixel_on_i     (pixel_on_i),
    .rec_valid_o    (rec_valid),
    .sum_x_o        (f_sum_x),
    .sum_y_o        (f_sum_y),
    .count_o        (f_count),
    .half_w_o       (f_half_w),
    .half_h_o       (f_half_h)
  );

  // Gains are taken with the frame so the back end sees a consistent set
  assign rec_wdata = {f_sum_x, f_sum_y, f_count, f_half_w, f_half_h,
                      forward_gain_q, turn_gain_q};
  assign {b_sum_x, b_sum_y, b_count, b_half_w, b_half_h, b_fgain, b_tgain} = rec_rdata;

  mcf_fifo #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .wdata_i (rec_wdata),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .rdata_o (rec_rdata),
    .empty_o (rec_empty)
  );

  mcf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_empty_i    (rec_empty),
    .rec_pop_o      (rec_pop),
    .sum_x_i        (b_sum_x),
    .sum_y_i        (b_sum_y),
    .count_i        (b_count),
    .half_w_i       (b_half_w),
    .half_h_i       (b_half_h),
    .forward_gain_i (b_fgain),
    .turn_gain_i    (b_tgain),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_w)
  );

  mcf_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_w),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_r),
    .empty_o (empty)
  );

  assign target_found_o    = res_r.target_found;
  assign centroid_x_o      = res_r.centroid_x;
  assign centroid_y_o      = res_r.centroid_y;
  assign set_pixel_count_o = res_r.set_pixel_count;
  assign forward_speed_o   = res_r.forward_speed;
  assign turn_speed_o      = res_r.turn_speed;

endmodule

// ===== src/mcf_fifo.sv =====
// ----------------------------------------------------------------------------
// mcf_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module mcf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    num_q, num_d;
  logic             do_push, do_pop;

  assign full_o  = (num_q == NW'(DEPTH));
  assign empty_o = (num_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    num_d    = num_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      num_d = num_q + 1'b1;
    end else if (do_pop && !do_push) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      num_q    <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/mcf_front.sv =====
// ----------------------------------------------------------------------------
// mcf_front
// Raster position counters and per-frame sums of set pixel positions.
// ----------------------------------------------------------------------------
module mcf_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned YW  = $clog2(MAX_HEIGHT),
  localparam int unsigned QW  = (XW > YW) ? XW : YW,
  localparam int unsigned CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int unsigned SW  = CW + QW,
  localparam int unsigned HXW = $clog2(MAX_WIDTH / 2 + 1),
  localparam int unsigned HYW = $clog2(MAX_HEIGHT / 2 + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [11:0]    frame_width_i,
  input  logic [11:0]    frame_height_i,
  input  logic           take_i,
  input  logic           pixel_on_i,
  output logic           rec_valid_o,
  output logic [SW-1:0]  sum_x_o,
  output logic [SW-1:0]  sum_y_o,
  output logic [CW-1:0]  count_o,
  output logic [HXW-1:0] half_w_o,
  output logic [HYW-1:0] half_h_o
);

  logic [31:0]   w_eff, h_eff;
  logic [XW-1:0] last_col;
  logic [YW-1:0] last_row;
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [SW-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          row_end, frame_end;

  always_comb begin
    w_eff = 32'(frame_width_i);
    h_eff = 32'(frame_height_i);
    if (w_eff == 32'd0) begin
      w_eff = 32'd1;
    end else if (w_eff > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end
    if (h_eff == 32'd0) begin
      h_eff = 32'd1;
    end else if (h_eff > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end
  end

  assign last_col  = XW'(w_eff - 32'd1);
  assign last_row  = YW'(h_eff - 32'd1);
  assign half_w_o  = HXW'(w_eff >> 1);
  assign half_h_o  = HYW'(h_eff >> 1);
  assign row_end   = (col_q >= last_col);
  assign frame_end = row_end && (row_q >= last_row);

  always_comb begin
    sum_x_o = sum_x_q;
    sum_y_o = sum_y_q;
    count_o = cnt_q;
    if (pixel_on_i) begin
      sum_x_o = sum_x_q + SW'(col_q);
      sum_y_o = sum_y_q + SW'(row_q);
      count_o = cnt_q + 1'b1;
    end
  end

  assign rec_valid_o = take_i && frame_end;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (take_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      if (frame_end) begin
        sum_x_d = '0;
        sum_y_d = '0;
        cnt_d   = '0;
      end else begin
        sum_x_d = sum_x_o;
        sum_y_d = sum_y_o;
        cnt_d   = count_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== src/mcf_back.sv =====
// ----------------------------------------------------------------------------
// mcf_back
// Per-frame centroid division, offset gain products and speed saturation.
// ----------------------------------------------------------------------------
module mcf_back #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned YW  = $clog2(MAX_HEIGHT),
  localparam int unsigned QW  = (XW > YW) ? XW : YW,
  localparam int unsigned CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int unsigned SW  = CW + QW,
  localparam int unsigned HXW = $clog2(MAX_WIDTH / 2 + 1),
  localparam int unsigned HYW = $clog2(MAX_HEIGHT / 2 + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_empty_i,
  output logic             rec_pop_o,
  input  logic [SW-1:0]    sum_x_i,
  input  logic [SW-1:0]    sum_y_i,
  input  logic [CW-1:0]    count_i,
  input  logic [HXW-1:0]   half_w_i,
  input  logic [HYW-1:0]   half_h_i,
  input  logic [15:0]      forward_gain_i,
  input  logic [15:0]      turn_gain_i,
  input  logic             res_full_i,
  output logic             res_push_o,
  output mcf_pkg::result_t res_o
);

  import mcf_pkg::*;

  localparam int unsigned OW  = QW + 2;
  localparam int unsigned PRW = OW + 17;
  localparam int unsigned STW = $clog2(QW + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic [SW-1:0]          rem_x_q, rem_y_q, dsh_q;
  logic [QW-1:0]          qx_q, qy_q;
  logic [CW-1:0]          cnt_q;
  logic [STW-1:0]         step_q;
  logic [HXW-1:0]         hw_q;
  logic [HYW-1:0]         hh_q;
  logic [15:0]            fg_q, tg_q;
  logic signed [PRW-1:0]  prod_f_q, prod_t_q;
  logic                   ge_x, ge_y, found;
  logic signed [OW-1:0]   off_x, off_y;

  assign ge_x  = (rem_x_q >= dsh_q);
  assign ge_y  = (rem_y_q >= dsh_q);
  assign off_x = $signed(OW'(hw_q) - OW'(qx_q));
  assign off_y = $signed(OW'(hh_q) - OW'(qy_q));
  assign found = (cnt_q != '0);

  assign rec_pop_o  = (state_q == ST_IDLE) && !rec_empty_i;
  assign res_push_o = (state_q == ST_OUT) && !res_full_i;

  always_comb begin
    res_o                 = '0;
    res_o.set_pixel_count = 23'(cnt_q);
    if (found) begin
      res_o.target_found  = 1'b1;
      res_o.centroid_x    = 11'(qx_q);
      res_o.centroid_y    = 11'(qy_q);
      res_o.forward_speed = speed_sat(48'(prod_f_q));
      res_o.turn_speed    = speed_sat(48'(prod_t_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rem_x_q  <= '0;
      rem_y_q  <= '0;
      dsh_q    <= '0;
      qx_q     <= '0;
      qy_q     <= '0;
      cnt_q    <= '0;
      step_q   <= '0;
      hw_q     <= '0;
      hh_q     <= '0;
      fg_q     <= '0;
      tg_q     <= '0;
      prod_f_q <= '0;
      prod_t_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!rec_empty_i) begin
            rem_x_q <= sum_x_i;
            rem_y_q <= sum_y_i;
            dsh_q   <= SW'(count_i) << (QW - 1);
            qx_q    <= '0;
            qy_q    <= '0;
            cnt_q   <= count_i;
            hw_q    <= half_w_i;
            hh_q    <= half_h_i;
            fg_q    <= forward_gain_i;
            tg_q    <= turn_gain_i;
            step_q  <= STW'(QW - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ge_x) begin
            rem_x_q <= rem_x_q - dsh_q;
          end
          if (ge_y) begin
            rem_y_q <= rem_y_q - dsh_q;
          end
          qx_q  <= QW'(qx_q << 1) | QW'(ge_x);
          qy_q  <= QW'(qy_q << 1) | QW'(ge_y);
          dsh_q <= dsh_q >> 1;
          if (step_q == '0) begin
            state_q <= ST_MUL;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_MUL: begin
          prod_f_q <= off_y * $signed({1'b0, fg_q});
          prod_t_q <= off_x * $signed({1'b0, tg_q});
          state_q  <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/mask_centroid_follow_command_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mask_centroid_follow_command_test
// ----------------------------------------------------------------------------
// Streams binary mask pixels into the centroid block and checks every frame
// result against an in-bench tracker of column and row position, position
// sums and set pixel count, or against stored results for most table rows. A
// short table covers the empty frame, the smallest frames, zero-size registers,
// full and zero gains and a frame size change part way through a frame. An
// oversized frame size register is left mid-frame ahead of the held-off section,
// a long output hold-off that backs the input up. The random part then runs
// many small geometries with random pixel density, random gaps on both sides
// and a stretch with no gaps. Register writes are read back each time.
// ----------------------------------------------------------------------------
module mask_centroid_follow_command_test;
  import mcf_pkg::*;

  localparam int unsigned SIZE_MAX      = 2048;
  localparam longint      SPEED_LIMIT   = 67108864;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_PIXELS = 680;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] fwd_gain;
    logic [15:0] turn_gain;
    int unsigned npix;
    logic [15:0] pattern;
    bit          typed;
    result_t     outcome;
  } frame_row_t;

  // pattern bit i is pixel i of the frame, raster order
  frame_row_t frame_plan [8] = '{
    '{12'd1, 12'd1, 16'd0, 16'd0, 1, 16'h0001 ^ 16'h0001, 1'b1,
      '{1'b0, 11'd0, 11'd0, 23'd0, 28'sd0, 28'sd0}},
    '{12'd1, 12'd1, 16'd0, 16'd0, 1, 16'h0001, 1'b1,
      '{1'b1, 11'd0, 11'd0, 23'd1, 28'sd0, 28'sd0}},
    '{12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 1, 16'h0001, 1'b1,
      '{1'b1, 11'd0, 11'd0, 23'd1, 28'sd0, 28'sd0}},
    '{12'd2, 12'd2, 16'hFFFF, 16'hFFFF, 4, 16'h000F, 1'b1,
      '{1'b1, 11'd0, 11'd0, 23'd4, 28'sd65535, 28'sd65535}},
    '{12'd3, 12'd2, 16'd131, 16'd197, 6, 16'h0020, 1'b1,
      '{1'b1, 11'd2, 11'd1, 23'd1, 28'sd0, -28'sd197}},
    '{12'd4, 12'd4, 16'd1000, 16'd3000, 6, 16'h002D, 1'b0, '0},
    '{12'd2, 12'd1, 16'd1000, 16'd3000, 1, 16'h0001, 1'b0, '0},
    '{12'd2, 12'd2, 16'd7, 16'd9, 4, 16'h0006, 1'b0, '0}
  };

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [CFG_DW-1:0] pwdata     = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              push       = 1'b0;
  logic              full;
  logic              pixel_on_i = 1'b0;
  logic              empty;
  logic              pop        = 1'b0;
  logic              target_found_o;
  logic [10:0]       centroid_x_o;
  logic [10:0]       centroid_y_o;
  logic [22:0]       set_pixel_count_o;
  speed_t            forward_speed_o;
  speed_t            turn_speed_o;

  // tracker state
  logic [11:0] geo_width  = FRAME_WIDTH_RST;
  logic [11:0] geo_height = FRAME_HEIGHT_RST;
  logic [15:0] fwd_gain   = FORWARD_GAIN_RST;
  logic [15:0] turn_gain  = TURN_GAIN_RST;
  logic [10:0] col_pos    = '0;
  logic [10:0] row_pos    = '0;
  logic [33:0] col_sum    = '0;
  logic [33:0] row_sum    = '0;
  logic [22:0] lit_count  = '0;
  result_t     pending_centroids [$];

  int unsigned err_cnt         = 0;
  int unsigned pixels_fed      = 0;
  int unsigned directed_pixels = 0;
  int unsigned geometries      = 0;
  int unsigned results_seen    = 0;
  int unsigned targets_seen    = 0;
  int unsigned cycle_cnt       = 0;
  int unsigned tx_idle_pct     = IDLE_PCT;
  int unsigned rx_idle_pct     = IDLE_PCT;
  int unsigned hold_left       = 0;
  bit          hold_req        = 1'b0;

  mask_centroid_follow_command DUT (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .push,
    .full,
    .pixel_on_i,
    .empty,
    .pop,
    .target_found_o,
    .centroid_x_o,
    .centroid_y_o,
    .set_pixel_count_o,
    .forward_speed_o,
    .turn_speed_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned usable_size(logic [11:0] v);
    if (v == 0) return 1;
    if (v > SIZE_MAX) return SIZE_MAX;
    return v;
  endfunction

  function automatic speed_t follow_speed(longint offset, logic [15:0] gain);
    longint p;
    p = offset * longint'(gain);
    if (p > SPEED_LIMIT) p = SPEED_LIMIT;
    else if (p < -SPEED_LIMIT) p = -SPEED_LIMIT;
    return speed_t'(p);
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(4))
      0: return 0;
      1: return 3;
      2: return 97;
      3: return 100;
      default: return 50;
    endcase
  endfunction

  // advance position by one accepted pixel; gives the frame result at frame end
  task automatic follow_pixel(input logic lit, output bit frame_done, output result_t res);
    int unsigned w;
    int unsigned h;
    bit          row_end;
    longint      cx;
    longint      cy;
    w          = usable_size(geo_width);
    h          = usable_size(geo_height);
    row_end    = col_pos >= w - 1;
    frame_done = row_end && row_pos >= h - 1;
    res        = '0;
    if (lit) begin
      col_sum   += col_pos;
      row_sum   += row_pos;
      lit_count += 23'd1;
    end
    if (row_end) begin
      col_pos = '0;
      row_pos = frame_done ? 11'd0 : row_pos + 11'd1;
    end else begin
      col_pos = col_pos + 11'd1;
    end
    if (frame_done) begin
      if (lit_count != 0) begin
        cx                  = longint'(col_sum) / longint'(lit_count);
        cy                  = longint'(row_sum) / longint'(lit_count);
        res.target_found    = 1'b1;
        res.centroid_x      = cx[10:0];
        res.centroid_y      = cy[10:0];
        res.set_pixel_count = lit_count;
        res.forward_speed   = follow_speed(longint'(h / 2) - cy, fwd_gain);
        res.turn_speed      = follow_speed(longint'(w / 2) - cx, turn_gain);
      end
      col_sum   = '0;
      row_sum   = '0;
      lit_count = '0;
    end
  endtask

  task automatic send_pixel(input logic lit, output bit frame_done, output result_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      push       <= 1'b0;
      pixel_on_i <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    push       <= 1'b1;
    pixel_on_i <= lit;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    follow_pixel(lit, frame_done, res);
    pixels_fed++;
  endtask

  task automatic feed_run(input int unsigned n, input int unsigned pct);
    bit      done;
    result_t res;
    repeat (n) begin
      send_pixel($urandom_range(99) < pct, done, res);
      if (done) pending_centroids.push_back(res);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_access(input bit wr, input reg_idx_e idx, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_readback(input reg_idx_e idx, input logic [31:0] want);
    logic [31:0] got;
    reg_access(1'b0, idx, '0, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", idx.name(), want, got);
      err_cnt++;
    end
  endtask

  // upper bits of each write carry noise the register must drop
  task automatic set_geometry(input logic [11:0] w, input logic [11:0] h,
                              input logic [15:0] fg, input logic [15:0] tg);
    logic [31:0] noise;
    logic [31:0] ignored;
    wait_idle();
    noise = $urandom;
    reg_access(1'b1, REG_FRAME_WIDTH, {noise[31:12], w}, ignored);
    noise = $urandom;
    reg_access(1'b1, REG_FRAME_HEIGHT, {noise[31:12], h}, ignored);
    noise = $urandom;
    reg_access(1'b1, REG_FORWARD_GAIN, {noise[31:16], fg}, ignored);
    noise = $urandom;
    reg_access(1'b1, REG_TURN_GAIN, {noise[31:16], tg}, ignored);
    geo_width  = w;
    geo_height = h;
    fwd_gain   = fg;
    turn_gain  = tg;
    reg_readback(REG_FRAME_WIDTH, {20'd0, w});
    reg_readback(REG_FRAME_HEIGHT, {20'd0, h});
    reg_readback(REG_FORWARD_GAIN, {16'd0, fg});
    reg_readback(REG_TURN_GAIN, {16'd0, tg});
    geometries++;
  endtask

  task automatic field_check(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // output side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_centroids.size() == 0) begin
        $error("frame result with none outstanding");
        err_cnt++;
      end else begin
        want = pending_centroids.pop_front();
        field_check("target_found", want.target_found, target_found_o);
        field_check("centroid_x", want.centroid_x, centroid_x_o);
        field_check("centroid_y", want.centroid_y, centroid_y_o);
        field_check("set_pixel_count", want.set_pixel_count, set_pixel_count_o);
        field_check("forward_speed", want.forward_speed, forward_speed_o);
        field_check("turn_speed", want.turn_speed, turn_speed_o);
        results_seen++;
        if (want.target_found) targets_seen++;
      end
    end
  end

  initial begin
    bit          done;
    result_t     res;
    int unsigned rand_start;
    int unsigned phase;
    int unsigned frame_len;
    bit          calm;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    reg_readback(REG_FRAME_WIDTH, 32'(FRAME_WIDTH_RST));
    reg_readback(REG_FRAME_HEIGHT, 32'(FRAME_HEIGHT_RST));
    reg_readback(REG_FORWARD_GAIN, 32'(FORWARD_GAIN_RST));
    reg_readback(REG_TURN_GAIN, 32'(TURN_GAIN_RST));

    foreach (frame_plan[k]) begin
      set_geometry(frame_plan[k].width, frame_plan[k].height,
                   frame_plan[k].fwd_gain, frame_plan[k].turn_gain);
      for (int i = 0; i < frame_plan[k].npix; i++) begin
        send_pixel(frame_plan[k].pattern[i], done, res);
        if (done) pending_centroids.push_back(frame_plan[k].typed ? frame_plan[k].outcome : res);
      end
    end
    directed_pixels = pixels_fed;

    // oversized frame size, frame left open for the next geometry
    set_geometry(12'hFFF, 12'hFFF, 16'hFFFF, pick_gain());
    feed_run(40, 50);

    // one result per pixel while the output is held off
    set_geometry(12'd1, 12'd1, pick_gain(), pick_gain());
    hold_req = 1'b1;
    feed_run(30, 50);

    rand_start = pixels_fed;
    phase      = 0;
    while (pixels_fed - rand_start < RANDOM_PIXELS) begin
      set_geometry(12'($urandom_range(0, 9)), 12'($urandom_range(0, 6)),
                   pick_gain(), pick_gain());
      calm        = (phase >= 4 && phase < 10);
      tx_idle_pct = calm ? 0 : IDLE_PCT;
      rx_idle_pct = calm ? 0 : IDLE_PCT;
      frame_len   = usable_size(geo_width) * usable_size(geo_height);
      repeat ($urandom_range(1, 5)) feed_run(frame_len, pick_density());
      // may leave a frame open so the next geometry lands mid-frame
      if ($urandom_range(3) == 0) feed_run($urandom_range(1, frame_len), 50);
      phase++;
    end

    wait_idle();
    $display("Fed %0d mask pixels (%0d from the table) over %0d frame geometries.",
             pixels_fed, directed_pixels, geometries);
    $display("Checked %0d frame results, %0d with a target, incl. a backed-up input.",
             results_seen, targets_seen);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mcf_pkg.sv
src/mcf_fifo.sv
src/mcf_front.sv
src/mcf_back.sv
src/mask_centroid_follow_command.sv
tb/sv/mask_centroid_follow_command_test.sv
